// File: hdl/aad_pkg.sv
package aad_pkg;

   localparam int MAX_SOURCE_SIZE = 4096;
   localparam int MAX_TILE_SIZE   = 256;

   localparam logic [1:0] CSR_SOURCE_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_SOURCE_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_TILE_WIDTH    = 2'd2;
   localparam logic [1:0] CSR_TILE_HEIGHT   = 2'd3;

   typedef struct packed {
      logic [7:0] pixel;
      logic       first_pixel;
   } word_type;

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [23:0] divisor;
   } div_req_type;

endpackage

// File: hdl/area_average_downscale.sv
// Area-average downscaler: 8-bit grey source pixels come in raster order (first_pixel
// marks source pixel 0,0) and each tile pixel is sent once the last source pixel of its
// window has arrived, carrying the truncated window mean. A 4-word input queue takes
// pixels while the back end works; the back end handles one pixel at a time, and it
// takes longer while the output is stalled. Its time per pixel is set by the shared
// radix-2 divider: each pixel needs four to fourteen window-bound divisions, plus one
// for the mean when a window closes.
// Registers are to be written only while idle; the block itself does not enforce this.
module area_average_downscale (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_pixel,
   input  logic        req_first_pixel,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_tile_col,
   output logic [7:0]  rsp_tile_row,
   output logic [7:0]  rsp_mean_value,
   output logic        rsp_last_tile,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data
);

   aad_pkg::word_type    req_word, q_word;
   aad_pkg::div_req_type div_req;
   logic                 q_valid, q_pop, div_done;
   logic [31:0]          quotient;

   assign req_word.pixel       = req_pixel;
   assign req_word.first_pixel = req_first_pixel;

   aad_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .q_valid   (q_valid),
      .q_word    (q_word),
      .q_pop     (q_pop)
   );

   aad_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_done (div_done),
      .quotient (quotient)
   );

   aad_core u_core (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_word         (q_word),
      .q_pop          (q_pop),
      .div_req        (div_req),
      .div_done       (div_done),
      .quotient       (quotient),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_tile_col   (rsp_tile_col),
      .rsp_tile_row   (rsp_tile_row),
      .rsp_mean_value (rsp_mean_value),
      .rsp_last_tile  (rsp_last_tile)
   );

   a_pop_needs_word: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("queue popped while empty");

   a_empty_not_stalled: assert property (@(posedge clock) disable iff (reset)
      !q_valid |-> !req_stall) else $error("input stalled with empty queue");

   a_done_single: assert property (@(posedge clock) disable iff (reset)
      div_done |=> !div_done) else $error("divider done held");

   a_no_start_during_done: assert property (@(posedge clock) disable iff (reset)
      div_req.start |=> !div_done) else $error("divider done right after start");

endmodule

// File: hdl/aad_queue.sv
module aad_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  aad_pkg::word_type req_word,
   output logic              q_valid,
   output aad_pkg::word_type q_word,
   input  logic              q_pop
);

   aad_pkg::word_type entry_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       push;

   assign req_stall = (count_ff == 3'd4);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 3'd0);
   assign q_word    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      count_in  = count_ff + {2'd0, push} - {2'd0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= req_word;
      end
   end

endmodule

// File: hdl/aad_div.sv
module aad_div (
   input  logic                 clock,
   input  logic                 reset,
   input  aad_pkg::div_req_type div_req,
   output logic                 div_done,
   output logic [31:0]          quotient
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] dvd_ff, dvd_in;
   logic [23:0] rem_ff, rem_in;
   logic [23:0] dsr_ff, dsr_in;
   logic [24:0] rem_sh;
   logic        fits;

   assign div_done = done_ff;
   assign quotient = dvd_ff;
   assign rem_sh   = {rem_ff, dvd_ff[31]};
   assign fits     = rem_sh >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? 24'(rem_sh - {1'b0, dsr_ff}) : rem_sh[23:0];
         dvd_in = {dvd_ff[30:0], fits};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

endmodule

// File: hdl/aad_core.sv
module aad_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  aad_pkg::word_type    q_word,
   output logic                 q_pop,
   output aad_pkg::div_req_type div_req,
   input  logic                 div_done,
   input  logic [31:0]          quotient,
   input  logic                 csr_write,
   input  logic [1:0]           csr_index,
   input  logic [12:0]          csr_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_tile_col,
   output logic [7:0]           rsp_tile_row,
   output logic [7:0]           rsp_mean_value,
   output logic                 rsp_last_tile
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_ADV_C, ST_ADV_C_W, ST_ADV_R, ST_ADV_R_W,
      ST_Y_LO, ST_Y_LO_W, ST_Y_HI, ST_Y_HI_W,
      ST_X_LO, ST_X_LO_W, ST_X_HI, ST_X_HI_W,
      ST_RD, ST_UPD, ST_MEAN, ST_MEAN_W, ST_EMIT,
      ST_NEXT_X, ST_NEXT_Y, ST_STEP
   } state_type;

   state_type state_ff, state_in;

   logic [12:0] cfg_sw_ff, cfg_sw_in, cfg_sh_ff, cfg_sh_in;
   logic [8:0]  cfg_tw_ff, cfg_tw_in, cfg_th_ff, cfg_th_in;
   logic [12:0] sw_ff, sw_in, sh_ff, sh_in;
   logic [8:0]  tw_ff, tw_in, th_ff, th_in;
   logic [11:0] col_ff, col_in, row_ff, row_in;
   logic [7:0]  ftc_ff, ftc_in, ftr_ff, ftr_in;
   logic [7:0]  pix_ff, pix_in;
   logic        dy_ff, dy_in, dx_ff, dx_in, emitted_ff, emitted_in;
   logic [12:0] ylo_ff, ylo_in, yhi_ff, yhi_in, xlo_ff, xlo_in, xhi_ff, xhi_in;
   logic [31:0] sum_ff, sum_in;
   logic [23:0] count_ff, count_in;
   logic [7:0]  mean_ff, mean_in;
   logic        rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [7:0]  rsp_col_ff, rsp_col_in, rsp_row_ff, rsp_row_in, rsp_mean_ff, rsp_mean_in;
   aad_pkg::div_req_type div_ff, div_in;

   logic [31:0] sums_mem [2 * aad_pkg::MAX_TILE_SIZE];
   logic [31:0] mem_rd_ff;
   logic [8:0]  mem_addr;
   logic        mem_we;
   logic [31:0] mem_wdata;

   logic [12:0] sw_sat, sh_sat, tw_lim, th_lim, tw_sat13, th_sat13;
   logic [8:0]  y_cur, x_cur;
   logic [8:0]  mul_a, t_sel;
   logic [12:0] mul_b;
   logic [21:0] mul_p;
   logic        hi_sel;
   logic [31:0] bnd_dividend;
   logic [12:0] col13, row13, col_nx, row_nx;
   logic [25:0] count_p;
   logic        restart;

   always_comb begin
      sw_sat = (cfg_sw_ff < 13'd2) ? 13'd2 :
               (cfg_sw_ff > 13'(aad_pkg::MAX_SOURCE_SIZE)) ?
               13'(aad_pkg::MAX_SOURCE_SIZE) : cfg_sw_ff;
      sh_sat = (cfg_sh_ff < 13'd2) ? 13'd2 :
               (cfg_sh_ff > 13'(aad_pkg::MAX_SOURCE_SIZE)) ?
               13'(aad_pkg::MAX_SOURCE_SIZE) : cfg_sh_ff;
      tw_lim = (sw_sat < 13'(aad_pkg::MAX_TILE_SIZE)) ? sw_sat :
               13'(aad_pkg::MAX_TILE_SIZE);
      th_lim = (sh_sat < 13'(aad_pkg::MAX_TILE_SIZE)) ? sh_sat :
               13'(aad_pkg::MAX_TILE_SIZE);
      tw_sat13 = ({4'd0, cfg_tw_ff} < 13'd2) ? 13'd2 :
                 ({4'd0, cfg_tw_ff} > tw_lim) ? tw_lim : {4'd0, cfg_tw_ff};
      th_sat13 = ({4'd0, cfg_th_ff} < 13'd2) ? 13'd2 :
                 ({4'd0, cfg_th_ff} > th_lim) ? th_lim : {4'd0, cfg_th_ff};
   end

   assign y_cur    = {1'b0, ftr_ff} + {8'd0, dy_ff};
   assign x_cur    = {1'b0, ftc_ff} + {8'd0, dx_ff};
   assign col13    = {1'b0, col_ff};
   assign row13    = {1'b0, row_ff};
   assign mem_addr = {y_cur[0], x_cur[7:0]};
   assign count_p  = (xhi_ff - xlo_ff) * (yhi_ff - ylo_ff);

   // window bound: lo = i*S/t, hi = ((i+1)*S + t-1)/t
   always_comb begin
      mul_a  = y_cur;
      mul_b  = sh_ff;
      t_sel  = th_ff;
      hi_sel = 1'b0;
      case (state_ff)
         ST_ADV_C: begin
            mul_a = {1'b0, ftc_ff} + 9'd1; mul_b = sw_ff; t_sel = tw_ff; hi_sel = 1'b1;
         end
         ST_ADV_R: begin
            mul_a = {1'b0, ftr_ff} + 9'd1; hi_sel = 1'b1;
         end
         ST_Y_HI: begin
            mul_a = y_cur + 9'd1; hi_sel = 1'b1;
         end
         ST_X_LO: begin
            mul_a = x_cur; mul_b = sw_ff; t_sel = tw_ff;
         end
         ST_X_HI: begin
            mul_a = x_cur + 9'd1; mul_b = sw_ff; t_sel = tw_ff; hi_sel = 1'b1;
         end
         default: begin
         end
      endcase
      mul_p        = mul_a * mul_b;
      bnd_dividend = {10'd0, mul_p} + (hi_sel ? {23'd0, t_sel - 9'd1} : 32'd0);
   end

   always_comb begin
      restart = q_word.first_pixel || col13 >= sw_sat || row13 >= sh_sat ||
                {5'd0, ftc_ff} >= tw_sat13 || {5'd0, ftr_ff} >= th_sat13;
      col_nx  = col13 + 13'd1;
      row_nx  = row13 + 13'd1;
   end

   always_comb begin
      state_in   = state_ff;
      cfg_sw_in  = cfg_sw_ff;
      cfg_sh_in  = cfg_sh_ff;
      cfg_tw_in  = cfg_tw_ff;
      cfg_th_in  = cfg_th_ff;
      sw_in      = sw_ff;
      sh_in      = sh_ff;
      tw_in      = tw_ff;
      th_in      = th_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      ftc_in     = ftc_ff;
      ftr_in     = ftr_ff;
      pix_in     = pix_ff;
      dy_in      = dy_ff;
      dx_in      = dx_ff;
      emitted_in = emitted_ff;
      ylo_in     = ylo_ff;
      yhi_in     = yhi_ff;
      xlo_in     = xlo_ff;
      xhi_in     = xhi_ff;
      sum_in     = sum_ff;
      count_in   = count_ff;
      mean_in    = mean_ff;
      rsp_col_in = rsp_col_ff;
      rsp_row_in = rsp_row_ff;
      rsp_mean_in = rsp_mean_ff;
      rsp_last_in = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      div_in     = div_ff;
      div_in.start = 1'b0;
      q_pop      = 1'b0;
      mem_we     = 1'b0;
      mem_wdata  = ((col13 == xlo_ff) && (row13 == ylo_ff)) ?
                   {24'd0, pix_ff} : mem_rd_ff + {24'd0, pix_ff};

      if (csr_write) begin
         unique case (csr_index)
            aad_pkg::CSR_SOURCE_WIDTH:  cfg_sw_in = csr_data;
            aad_pkg::CSR_SOURCE_HEIGHT: cfg_sh_in = csr_data;
            aad_pkg::CSR_TILE_WIDTH:    cfg_tw_in = csr_data[8:0];
            aad_pkg::CSR_TILE_HEIGHT:   cfg_th_in = csr_data[8:0];
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               pix_in = q_word.pixel;
               sw_in  = sw_sat;
               sh_in  = sh_sat;
               tw_in  = tw_sat13[8:0];
               th_in  = th_sat13[8:0];
               if (restart) begin
                  col_in = '0;
                  row_in = '0;
                  ftc_in = '0;
                  ftr_in = '0;
               end
               state_in = ST_ADV_C;
            end
         end
         ST_ADV_C: begin
            if ({1'b0, ftc_ff} + 9'd1 < tw_ff) begin
               div_in = '{start: 1'b1, dividend: bnd_dividend, divisor: {15'd0, t_sel}};
               state_in = ST_ADV_C_W;
            end else begin
               state_in = ST_ADV_R;
            end
         end
         ST_ADV_C_W: begin
            if (div_done) begin
               if (quotient <= {20'd0, col_ff}) ftc_in = ftc_ff + 8'd1;
               state_in = ST_ADV_R;
            end
         end
         ST_ADV_R: begin
            dy_in = 1'b0;
            emitted_in = 1'b0;
            if ({1'b0, ftr_ff} + 9'd1 < th_ff) begin
               div_in = '{start: 1'b1, dividend: bnd_dividend, divisor: {15'd0, t_sel}};
               state_in = ST_ADV_R_W;
            end else begin
               state_in = ST_Y_LO;
            end
         end
         ST_ADV_R_W: begin
            if (div_done) begin
               if (quotient <= {20'd0, row_ff}) ftr_in = ftr_ff + 8'd1;
               state_in = ST_Y_LO;
            end
         end
         ST_Y_LO: begin
            if (y_cur >= th_ff) begin
               state_in = ST_STEP;
            end else begin
               div_in = '{start: 1'b1, dividend: bnd_dividend, divisor: {15'd0, t_sel}};
               state_in = ST_Y_LO_W;
            end
         end
         ST_Y_LO_W: begin
            if (div_done) begin
               ylo_in = quotient[12:0];
               state_in = ST_Y_HI;
            end
         end
         ST_Y_HI: begin
            div_in = '{start: 1'b1, dividend: bnd_dividend, divisor: {15'd0, t_sel}};
            state_in = ST_Y_HI_W;
         end
         ST_Y_HI_W: begin
            if (div_done) begin
               yhi_in = quotient[12:0];
               dx_in  = 1'b0;
               state_in = (row13 >= ylo_ff && row13 < quotient[12:0]) ? ST_X_LO : ST_NEXT_Y;
            end
         end
         ST_X_LO: begin
            if (x_cur >= tw_ff) begin
               state_in = ST_NEXT_X;
            end else begin
               div_in = '{start: 1'b1, dividend: bnd_dividend, divisor: {15'd0, t_sel}};
               state_in = ST_X_LO_W;
            end
         end
         ST_X_LO_W: begin
            if (div_done) begin
               xlo_in = quotient[12:0];
               state_in = ST_X_HI;
            end
         end
         ST_X_HI: begin
            div_in = '{start: 1'b1, dividend: bnd_dividend, divisor: {15'd0, t_sel}};
            state_in = ST_X_HI_W;
         end
         ST_X_HI_W: begin
            if (div_done) begin
               xhi_in = quotient[12:0];
               state_in = (col13 >= xlo_ff && col13 < quotient[12:0]) ? ST_RD : ST_NEXT_X;
            end
         end
         ST_RD: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            mem_we = 1'b1;
            sum_in = mem_wdata;
            if (col13 == xhi_ff - 13'd1 && row13 == yhi_ff - 13'd1 && !emitted_ff) begin
               count_in = count_p[23:0];
               state_in = ST_MEAN;
            end else begin
               state_in = ST_NEXT_X;
            end
         end
         ST_MEAN: begin
            div_in = '{start: 1'b1, dividend: sum_ff, divisor: count_ff};
            state_in = ST_MEAN_W;
         end
         ST_MEAN_W: begin
            if (div_done) begin
               mean_in = (quotient > 32'd255) ? 8'hff : quotient[7:0];
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_col_in   = x_cur[7:0];
               rsp_row_in   = y_cur[7:0];
               rsp_mean_in  = mean_ff;
               rsp_last_in  = (x_cur == tw_ff - 9'd1) && (y_cur == th_ff - 9'd1);
               emitted_in   = 1'b1;
               state_in     = ST_NEXT_X;
            end
         end
         ST_NEXT_X: begin
            if (!dx_ff) begin
               dx_in = 1'b1;
               state_in = ST_X_LO;
            end else begin
               state_in = ST_NEXT_Y;
            end
         end
         ST_NEXT_Y: begin
            if (!dy_ff) begin
               dy_in = 1'b1;
               state_in = ST_Y_LO;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            col_in = col_nx[11:0];
            if (col_nx >= sw_ff) begin
               col_in = '0;
               ftc_in = '0;
               row_in = row_nx[11:0];
               if (row_nx >= sh_ff) begin
                  row_in = '0;
                  ftr_in = '0;
               end
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cfg_sw_ff    <= 13'd256;
         cfg_sh_ff    <= 13'd256;
         cfg_tw_ff    <= 9'd16;
         cfg_th_ff    <= 9'd16;
         col_ff       <= '0;
         row_ff       <= '0;
         ftc_ff       <= '0;
         ftr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         div_ff.start <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_sw_ff    <= cfg_sw_in;
         cfg_sh_ff    <= cfg_sh_in;
         cfg_tw_ff    <= cfg_tw_in;
         cfg_th_ff    <= cfg_th_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         ftc_ff       <= ftc_in;
         ftr_ff       <= ftr_in;
         rsp_valid_ff <= rsp_valid_in;
         div_ff.start <= div_in.start;
      end
      div_ff.dividend <= div_in.dividend;
      div_ff.divisor  <= div_in.divisor;
      sw_ff       <= sw_in;
      sh_ff       <= sh_in;
      tw_ff       <= tw_in;
      th_ff       <= th_in;
      pix_ff      <= pix_in;
      dy_ff       <= dy_in;
      dx_ff       <= dx_in;
      emitted_ff  <= emitted_in;
      ylo_ff      <= ylo_in;
      yhi_ff      <= yhi_in;
      xlo_ff      <= xlo_in;
      xhi_ff      <= xhi_in;
      sum_ff      <= sum_in;
      count_ff    <= count_in;
      mean_ff     <= mean_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_mean_ff <= rsp_mean_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sums_mem[mem_addr] <= mem_wdata;
      end
      mem_rd_ff <= sums_mem[mem_addr];
   end

   assign div_req        = div_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tile_col   = rsp_col_ff;
   assign rsp_tile_row   = rsp_row_ff;
   assign rsp_mean_value = rsp_mean_ff;
   assign rsp_last_tile  = rsp_last_ff;

endmodule

// File: test/area_average_downscale_check.sv
`timescale 1ns / 1ps

module area_average_downscale_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_pixel,
   input  logic        req_first_pixel,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_tile_col,
   input  logic [7:0]  rsp_tile_row,
   input  logic [7:0]  rsp_mean_value,
   input  logic        rsp_last_tile,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data,
   output int          fail_count,
   output int          pending,
   output int          tiles_seen
);

   typedef struct {
      logic [7:0] col;
      logic [7:0] row;
      logic [7:0] mean;
      logic       last;
   } tile_pixel_type;

   tile_pixel_type  tile_queue[$];
   logic [12:0]     width_reg, height_reg;
   logic [8:0]      tile_w_reg, tile_h_reg;
   longint unsigned box_sum[2 * aad_pkg::MAX_TILE_SIZE];
   int unsigned     src_col, src_row, low_col, low_row;

   function automatic int unsigned clamp_source(input int unsigned v);
      if (v < 2) return 2;
      if (v > aad_pkg::MAX_SOURCE_SIZE) return aad_pkg::MAX_SOURCE_SIZE;
      return v;
   endfunction

   function automatic int unsigned clamp_tile(input int unsigned v, input int unsigned s);
      int unsigned lim;
      lim = (s < aad_pkg::MAX_TILE_SIZE) ? s : aad_pkg::MAX_TILE_SIZE;
      if (v < 2) return 2;
      if (v > lim) return lim;
      return v;
   endfunction

   function automatic int unsigned box_low(input int unsigned i, s, t);
      return 32'((longint'(i) * s) / t);
   endfunction

   function automatic int unsigned box_high(input int unsigned i, s, t);
      return 32'(((longint'(i) + 1) * s + t - 1) / t);
   endfunction

   task automatic accumulate_pixel(input logic [7:0] pix, input logic first);
      int unsigned    sw, sh, tw, th, x, y, xlo, xhi, ylo, yhi, idx;
      longint unsigned count, mean;
      bit             done;
      tile_pixel_type t;
      sw = clamp_source(width_reg);
      sh = clamp_source(height_reg);
      tw = clamp_tile(tile_w_reg, sw);
      th = clamp_tile(tile_h_reg, sh);
      done = 0;
      if (first || src_col >= sw || src_row >= sh || low_col >= tw || low_row >= th) begin
         src_col = 0;
         src_row = 0;
         low_col = 0;
         low_row = 0;
      end
      if (low_col + 1 < tw && box_high(low_col, sw, tw) <= src_col) low_col++;
      if (low_row + 1 < th && box_high(low_row, sh, th) <= src_row) low_row++;
      for (int dy = 0; dy < 2; dy++) begin
         y = low_row + dy;
         if (y >= th) continue;
         ylo = box_low(y, sh, th);
         yhi = box_high(y, sh, th);
         if (src_row < ylo || src_row >= yhi) continue;
         for (int dx = 0; dx < 2; dx++) begin
            x = low_col + dx;
            if (x >= tw) continue;
            xlo = box_low(x, sw, tw);
            xhi = box_high(x, sw, tw);
            if (src_col < xlo || src_col >= xhi) continue;
            idx = (y % 2) * aad_pkg::MAX_TILE_SIZE + x;
            if (src_col == xlo && src_row == ylo) box_sum[idx] = pix;
            else box_sum[idx] += pix;
            if (src_col == xhi - 1 && src_row == yhi - 1 && !done) begin
               count = longint'(xhi - xlo) * (yhi - ylo);
               mean = box_sum[idx] / count;
               t.col = x[7:0];
               t.row = y[7:0];
               t.mean = (mean > 255) ? 8'd255 : mean[7:0];
               t.last = (x == tw - 1 && y == th - 1);
               tile_queue.insert(tile_queue.size(), t);
               done = 1;
            end
         end
      end
      src_col++;
      if (src_col >= sw) begin
         src_col = 0;
         low_col = 0;
         src_row++;
         if (src_row >= sh) begin
            src_row = 0;
            low_row = 0;
         end
      end
   endtask

   task automatic compare_tile();
      tile_pixel_type t;
      if (tile_queue.size() == 0) begin
         $error("tile pixel (%0d,%0d) with none expected", rsp_tile_col, rsp_tile_row);
         fail_count++;
         return;
      end
      t = tile_queue.pop_front();
      tiles_seen++;
      if (rsp_tile_col !== t.col) begin
         $error("tile_col expected %0d actual %0d", t.col, rsp_tile_col);
         fail_count++;
      end
      if (rsp_tile_row !== t.row) begin
         $error("tile_row expected %0d actual %0d", t.row, rsp_tile_row);
         fail_count++;
      end
      if (rsp_mean_value !== t.mean) begin
         $error("mean_value expected %0d actual %0d", t.mean, rsp_mean_value);
         fail_count++;
      end
      if (rsp_last_tile !== t.last) begin
         $error("last_tile expected %0d actual %0d", t.last, rsp_last_tile);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         width_reg = 13'd256;
         height_reg = 13'd256;
         tile_w_reg = 9'd16;
         tile_h_reg = 9'd16;
         src_col = 0;
         src_row = 0;
         low_col = 0;
         low_row = 0;
         fail_count = 0;
         tiles_seen = 0;
         tile_queue.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               aad_pkg::CSR_SOURCE_WIDTH: width_reg = csr_data;
               aad_pkg::CSR_SOURCE_HEIGHT: height_reg = csr_data;
               aad_pkg::CSR_TILE_WIDTH: tile_w_reg = csr_data[8:0];
               aad_pkg::CSR_TILE_HEIGHT: tile_h_reg = csr_data[8:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) accumulate_pixel(req_pixel, req_first_pixel);
         if (rsp_valid && !rsp_stall) compare_tile();
      end
      pending = tile_queue.size();
   end

endmodule

// File: test/area_average_downscale_test.sv
`timescale 1ns / 1ps

module area_average_downscale_test;

   localparam int CYCLE_LIMIT = 6000000;
   localparam int SETTLE = 2000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid, req_stall, req_first_pixel;
   logic [7:0]  req_pixel;
   logic        rsp_valid, rsp_stall, rsp_last_tile;
   logic [7:0]  rsp_tile_col, rsp_tile_row, rsp_mean_value;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic [12:0] csr_data;
   int          fail_count, pending, tiles_seen;
   int          cycles = 0;
   int          pixels_sent, settings_used;
   logic        hold_off = 1'b0;
   bit          gaps_on;

   area_average_downscale uut (.*);

   area_average_downscale_check checker_i (.*);

   always #6 clock = ~clock;

   assign gaps_on = !(cycles >= 60000 && cycles < 160000);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= hold_off || (gaps_on && $urandom_range(0, 99) < 35);
   end

   // long receiver hold-off so the input queue fills and stalls
   initial begin
      wait (!reset);
      wait (pixels_sent >= 300);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (3000) @(posedge clock);
      hold_off <= 1'b0;
   end

   task automatic send_word(input logic [7:0] pix, input logic first);
      while (gaps_on && $urandom_range(0, 99) < 35) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= pix;
      req_first_pixel <= first;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pixels_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_sizes(input logic [12:0] sw, sh, tw, th);
      csr_write <= 1'b1;
      csr_index <= aad_pkg::CSR_SOURCE_WIDTH;
      csr_data <= sw;
      @(posedge clock);
      csr_index <= aad_pkg::CSR_SOURCE_HEIGHT;
      csr_data <= sh;
      @(posedge clock);
      csr_index <= aad_pkg::CSR_TILE_WIDTH;
      csr_data <= tw;
      @(posedge clock);
      csr_index <= aad_pkg::CSR_TILE_HEIGHT;
      csr_data <= th;
      @(posedge clock);
      csr_write <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [7:0] pick_pixel(input int mode);
      case (mode)
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   initial begin
      int sw, sh, tw, th, images, mode, cut, raw_tw;
      reset = 1;
      req_valid = 0;
      req_pixel = 0;
      req_first_pixel = 0;
      csr_write = 0;
      csr_index = aad_pkg::CSR_SOURCE_WIDTH;
      csr_data = 0;
      pixels_sent = 0;
      settings_used = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset sizes, partial image
      for (int i = 0; i < 3; i++) send_word(i == 1 ? 8'd255 : 8'd0, i == 0);
      drain();
      // below range: 2x2 source to 2x2 tile, then wrap without a mark
      set_sizes(13'd0, 13'd1, 13'd0, 13'd1);
      for (int i = 0; i < 8; i++) send_word(i[0] ? 8'd0 : 8'd255, i == 0);
      drain();
      // above range saturates
      set_sizes(13'h1FFF, 13'h1FFF, 13'h1FF, 13'h1FF);
      for (int i = 0; i < 3; i++) send_word(8'd255, i == 0);
      drain();
      // leave counters mid-image, then shrink so they fall outside
      set_sizes(13'd12, 13'd12, 13'd3, 13'd3);
      for (int i = 0; i < 30; i++) send_word(8'($urandom_range(0, 255)), i == 0);
      drain();
      set_sizes(13'd3, 13'd2, 13'd2, 13'd2);
      for (int i = 0; i < 6; i++) send_word(8'($urandom_range(0, 255)), 1'b0);
      drain();

      while (pixels_sent < 1500) begin
         sw = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(2, 10);
         sh = $urandom_range(2, 6);
         tw = $urandom_range(2, sw < 8 ? sw : 8);
         th = $urandom_range(2, sh);
         raw_tw = tw;
         if ($urandom_range(0, 7) == 0) raw_tw = $urandom_range(0, 1) ? 511 : 0;
         set_sizes(13'(sw), 13'(sh), 13'(raw_tw), 13'(th));
         images = $urandom_range(1, 3);
         mode = $urandom_range(0, 9);
         for (int im = 0; im < images; im++) begin
            cut = ($urandom_range(0, 19) == 0) ? $urandom_range(1, sw * sh - 1) : -1;
            for (int p = 0; p < sw * sh; p++)
               send_word(pick_pixel(mode), (im == 0 && p == 0) || p == cut);
         end
         if ($urandom_range(0, 3) == 0)
            for (int p = $urandom_range(1, sw * sh - 1); p > 0; p--)
               send_word(pick_pixel(mode), 1'b0);
         drain();
      end

      $display("%0d source pixels under %0d size settings gave %0d tile pixels",
               pixels_sent, settings_used, tiles_seen);
      if (fail_count == 0 && pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
